// File: rtl/core/olist_pkg.sv
// Shared types and constants of the ordered key list.
// Depends on nothing; every other file imports it.
package olist_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int KEY_W      = 16;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// command codes on the request channel
	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	// status codes on the response channel
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// operation broadcast to every cell
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_CMP,
		OP_DEL,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		key_t     key;
	} cell_ctl_t;

endpackage

// File: rtl/core/olist_req_if.sv
// Request channel: valid/ready handshake with cmd and key payload.
// Depends on olist_pkg.
interface olist_req_if;
	import olist_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	key_t       key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink   (input valid, input cmd, input key, output ready);

endinterface

// File: rtl/core/olist_rsp_if.sv
// Response channel: valid/ready handshake with status, value and last.
// Depends on olist_pkg.
interface olist_rsp_if;
	import olist_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	key_t       value;
	logic       last;

	modport source (output valid, output status, output value, output last, input ready);
	modport sink   (input valid, input status, input value, input last, output ready);

endinterface

// File: rtl/core/ordered_list_delete_by_key_unit.sv
// Top level of the ordered key list: control sequencer and the cell chain.
// Depends on olist_pkg, olist_req_if, olist_rsp_if, olist_cell.
//
//  channel | dir | payload                 | beat
//  --------+-----+-------------------------+---------------------------------
//  req     | in  | cmd[1:0], key[15:0]     | one command
//  rsp     | out | status[1:0], value[15:0]| one result, last marks the final
//          |     | last                    | result of a command
//
// Push answers directly; remove first compares in every cell, then a one-step
// shift closes the gap; dump starts, then gives one beat per live key,
// set by the chain rotating one slot per beat; a dump of an empty list
// answers directly.
// Reset clears all occupied flags and the count; keys are not cleared.
// A stalled rsp holds the result register and, through it, the sequencer.
// A new command is taken while the last result still waits, if rsp.ready.
module ordered_list_delete_by_key_unit
	import olist_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	olist_req_if.sink   req,
	olist_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_DUMP
	} state_t;

	state_t    state_q;
	cnt_t      cnt_q;      // live entries
	cnt_t      rem_q;      // keys left to emit in a dump
	logic      out_valid_q;
	logic [1:0] status_q;
	key_t      value_q;
	logic      last_q;

	cell_ctl_t ctl;
	logic      out_free;
	logic      req_take;
	logic      res_load;   // result register takes a new beat this cycle

	// chain wiring; index LIST_DEPTH is the tail boundary
	logic [LIST_DEPTH:0]   occ;
	logic [LIST_DEPTH:0]   hit;
	key_t                  keys [LIST_DEPTH+1];

	assign occ[LIST_DEPTH]  = 1'b0;
	assign keys[LIST_DEPTH] = '0;
	assign hit[0]           = 1'b0;

	genvar g;
	generate
		for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
			logic prev_occ;
			if (g == 0) begin : g_head
				assign prev_occ = 1'b1;
			end else begin : g_body
				assign prev_occ = occ[g-1];
			end
			olist_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.prev_occ (prev_occ),
				.next_occ (occ[g+1]),
				.next_key (keys[g+1]),
				.head_key (keys[0]),
				.hit_in   (hit[g]),
				.hit_out  (hit[g+1]),
				.occ      (occ[g]),
				.key      (keys[g])
			);
		end
	endgenerate

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_take  = req.valid && req.ready;

	assign rsp.valid  = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.value  = value_q;
	assign rsp.last   = last_q;

	// operation broadcast to the chain this cycle
	always_comb begin
		ctl.op   = OP_HOLD;
		ctl.key  = req.key;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					if (req.cmd == CMD_PUSH && !occ[LIST_DEPTH-1])
						ctl.op = OP_PUSH;
					else if (req.cmd == CMD_REMOVE)
						ctl.op = OP_CMP;
					// push answers at once, so does a dump of an empty list
					if (req.cmd == CMD_PUSH || (req.cmd == CMD_DUMP && !occ[0]))
						res_load = 1'b1;
				end
			end
			S_SRCH: begin
				if (out_free) begin
					ctl.op   = OP_DEL;
					res_load = 1'b1;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					ctl.op   = OP_ROT;
					res_load = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						case (req.cmd)
							CMD_PUSH: begin
								value_q     <= '0;
								last_q      <= 1'b1;
								if (occ[LIST_DEPTH-1]) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q + 1'b1;
								end
							end
							CMD_REMOVE: begin
								state_q <= S_SRCH;
							end
							CMD_DUMP: begin
								if (!occ[0]) begin
									status_q    <= ST_EMPTY;
									value_q     <= '0;
									last_q      <= 1'b1;
								end else begin
									rem_q   <= cnt_q;
									state_q <= S_DUMP;
								end
							end
							default: ;  // unused command: no result
						endcase
					end
				end
				S_SRCH: begin
					if (out_free) begin
						value_q     <= '0;
						last_q      <= 1'b1;
						// match anywhere shows at the chain's far end
						if (hit[LIST_DEPTH]) begin
							status_q <= ST_OK;
							cnt_q    <= cnt_q - 1'b1;
						end else begin
							status_q <= ST_NOT_FOUND;
						end
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						status_q    <= ST_OK;
						value_q     <= keys[0];
						last_q      <= (rem_q == cnt_t'(1));
						rem_q       <= rem_q - 1'b1;
						if (rem_q == cnt_t'(1))
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/olist_cell.sv
// One list slot: holds a key and its occupied flag, talks to both neighbors.
// Depends on olist_pkg.
module olist_cell
	import olist_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      prev_occ,  // slot toward the head is occupied
	input  logic      next_occ,  // slot toward the tail is occupied
	input  key_t      next_key,
	input  key_t      head_key,  // key of slot 0, for the dump rotation
	input  logic      hit_in,    // a match sits toward the head
	output logic      hit_out,
	output logic      occ,
	output key_t      key
);

	logic occ_q;
	logic match_q;
	key_t key_q;

	assign occ     = occ_q;
	assign key     = key_q;
	assign hit_out = hit_in | match_q;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_PUSH: begin
					if (prev_occ && !occ_q)
						occ_q <= 1'b1;
				end
				OP_CMP: begin
					match_q <= occ_q && (key_q == ctl.key);
				end
				OP_DEL: begin
					if (hit_out)
						occ_q <= next_occ;
					match_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// key storage, no reset
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH: begin
				if (prev_occ && !occ_q)
					key_q <= ctl.key;
			end
			OP_DEL: begin
				if (hit_out)
					key_q <= next_key;
			end
			OP_ROT: begin
				if (occ_q)
					key_q <= next_occ ? next_key : head_key;
			end
			default: ;
		endcase
	end

endmodule

// File: tb/tb_ordered_list_delete_by_key_unit.sv
// Self-checking testbench of ordered_list_delete_by_key_unit: push, remove and dump traffic.
// Depends on olist_pkg, olist_req_if, olist_rsp_if and the unit itself.
`timescale 1ns / 100ps

module tb_ordered_list_delete_by_key_unit;
	import olist_pkg::*;

	// cmd code that the unit leaves unused; it must give no beat at all
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int RAND_ITEMS   = 400;
	localparam int HOLD_AT      = 200;   // accepted commands before the long hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0] status;
		key_t       value;
		logic       last;
	} rsp_beat_t;

	// per-command note: a hand-typed single beat replaces the prediction
	typedef struct packed {
		bit         typed;
		logic [1:0] st;
	} item_tag_t;

	typedef struct packed {
		logic [1:0] cmd;
		key_t       key;
		int         reps;    // issued reps times, key stepping by one
		bit         typed;
		logic [1:0] st;
	} plan_row_t;

	localparam int N_PLAN = 24;

	// Directed part. Typed rows give one beat: value 0, last 1.
	plan_row_t plan [N_PLAN] = '{
		'{CMD_DUMP,   16'h0000,  1, 1'b1, ST_EMPTY},      // dump of an empty list
		'{CMD_REMOVE, 16'h1234,  1, 1'b1, ST_NOT_FOUND},  // remove from an empty list
		'{CMD_UNUSED, 16'hFFFF,  1, 1'b0, ST_OK},         // unused code, no beat
		'{CMD_PUSH,   16'h0000,  1, 1'b1, ST_OK},         // lowest key
		'{CMD_PUSH,   16'hFFFF,  1, 1'b1, ST_OK},         // highest key
		'{CMD_PUSH,   16'hFFFF,  1, 1'b1, ST_OK},         // duplicate accepted
		'{CMD_PUSH,   16'h5A5A,  1, 1'b1, ST_OK},
		'{CMD_DUMP,   16'hFFFF,  1, 1'b0, ST_OK},
		'{CMD_REMOVE, 16'hFFFF,  1, 1'b0, ST_OK},         // only first duplicate goes
		'{CMD_DUMP,   16'h0000,  1, 1'b0, ST_OK},
		'{CMD_REMOVE, 16'h0000,  1, 1'b0, ST_OK},         // head entry
		'{CMD_REMOVE, 16'h5A5A,  1, 1'b0, ST_OK},         // tail entry
		'{CMD_REMOVE, 16'h1111,  1, 1'b0, ST_OK},         // miss on a live list
		'{CMD_REMOVE, 16'hFFFF,  1, 1'b0, ST_OK},         // last live entry
		'{CMD_DUMP,   16'hA5A5,  1, 1'b1, ST_EMPTY},
		'{CMD_PUSH,   16'h8000, 32, 1'b0, ST_OK},         // fill to depth
		'{CMD_PUSH,   16'h0001,  1, 1'b1, ST_FULL},       // push on a full list
		'{CMD_DUMP,   16'h0000,  1, 1'b0, ST_OK},         // longest dump
		'{CMD_REMOVE, 16'h8010,  1, 1'b0, ST_OK},         // middle of a full list
		'{CMD_REMOVE, 16'h801F,  1, 1'b0, ST_OK},
		'{CMD_PUSH,   16'hA5A5,  1, 1'b0, ST_OK},
		'{CMD_DUMP,   16'h0000,  1, 1'b0, ST_OK},
		'{CMD_REMOVE, 16'h8000, 31, 1'b0, ST_OK},         // drain, one miss on the way
		'{CMD_DUMP,   16'h0000,  1, 1'b0, ST_OK}
	};

	logic clk = 1'b0;
	logic arst_n;

	olist_req_if req_ch ();
	olist_rsp_if rsp_ch ();

	ordered_list_delete_by_key_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// Shadow list: keys in arrival order and the live count
	key_t list_keys [LIST_DEPTH];
	int   live_cnt;

	rsp_beat_t due_results [$];   // beats still owed by the unit, oldest first
	item_tag_t item_tags [$];     // one per offered command, popped on acceptance
	key_t      pushed_keys [$];   // recent push keys, so removes hit often

	int n_errors, n_items, n_beats, n_full, n_missed, n_dumps, peak_depth;
	bit hold_active, hold_done, no_idle;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		n_errors++;
	endtask

	function automatic void expect_beat(input logic [1:0] st, input key_t v, input logic lst);
		due_results.push_back(rsp_beat_t'{st, v, lst});
	endfunction

	// Works out the beats one accepted command causes, and updates the shadow list.
	function automatic void predict_list_op(input logic [1:0] cmd, input key_t k);
		int hit;
		hit = -1;
		case (cmd)
		CMD_PUSH: begin
			if (live_cnt >= LIST_DEPTH) begin
				expect_beat(ST_FULL, '0, 1'b1);
				n_full++;
			end else begin
				list_keys[live_cnt] = k;
				live_cnt++;
				if (live_cnt > peak_depth)
					peak_depth = live_cnt;
				expect_beat(ST_OK, '0, 1'b1);
			end
		end
		CMD_REMOVE: begin
			// search only the live part; the first match wins
			for (int p = 0; p < live_cnt && hit < 0; p++)
				if (list_keys[p] == k)
					hit = p;
			if (hit < 0) begin
				expect_beat(ST_NOT_FOUND, '0, 1'b1);
				n_missed++;
			end else begin
				for (int p = hit; p < live_cnt - 1; p++)
					list_keys[p] = list_keys[p + 1];
				live_cnt--;
				expect_beat(ST_OK, '0, 1'b1);
			end
		end
		CMD_DUMP: begin
			n_dumps++;
			if (live_cnt == 0)
				expect_beat(ST_EMPTY, '0, 1'b1);
			else
				for (int p = 0; p < live_cnt; p++)
					expect_beat(ST_OK, list_keys[p], p == live_cnt - 1);
		end
		default: ;   // unused code: no beat, no change
		endcase
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Offers one command and returns once it is accepted. valid stays high
	// straight into the next command when no gap is drawn.
	task automatic offer(input logic [1:0] c, input key_t k, input bit typed,
		input logic [1:0] st);
		int gap;
		gap = (no_idle || hold_active) ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= c;
		req_ch.key   <= k;
		item_tags.push_back(item_tag_t'{typed, st});
		if (c == CMD_PUSH) begin
			pushed_keys.push_back(k);
			if (pushed_keys.size() > 48)
				void'(pushed_keys.pop_front());
		end
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Scoreboard: predict on each accepted command, then check each accepted
	// beat against the oldest one owed. Commands go first, so a beat can
	// never race its own prediction.
	always @(posedge clk) begin : scoreboard
		item_tag_t tag;
		rsp_beat_t got, want;
		int n0;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				tag = (item_tags.size() != 0) ? item_tags.pop_front() : '0;
				n0 = due_results.size();
				predict_list_op(req_ch.cmd, req_ch.key);
				if (tag.typed) begin
					while (due_results.size() > n0)
						void'(due_results.pop_back());
					expect_beat(tag.st, '0, 1'b1);
				end
				n_items++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_beat_t'{rsp_ch.status, rsp_ch.value, rsp_ch.last};
				n_beats++;
				if (due_results.size() == 0) begin
					report_mismatch("beat with nothing owed", int'(got), 0);
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.value !== want.value)
						report_mismatch("value", got.value, want.value);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
				end
			end
		end
	end

	// Receiver pacing: random ready runs, plus one long hold-off once enough
	// commands are in, while the sender keeps sending with no gaps so the
	// unit backs up and drops req.ready.
	initial begin : rsp_pacing
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && n_items >= HOLD_AT) begin
				hold_active = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_done = 1'b1;
			end else if ($urandom_range(0, 1)) begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 5) == 0 ? 60 : $urandom_range(1, 24)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat (1 + pick_gap()) @(posedge clk);
			end
		end
	end

	// Stimulus: reset, directed plan, then random phases
	initial begin : stimulus
		int r, bias, push_cut;
		logic [1:0] c;
		key_t k, pool_base;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_PUSH;
		req_ch.key   = '0;
		live_cnt     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PLAN; p++)
			for (int j = 0; j < plan[p].reps; j++)
				offer(plan[p].cmd, plan[p].key + key_t'(j), plan[p].typed, plan[p].st);

		// Random part in phases of 40: each phase leans to filling, draining
		// or balance, and some phases send back to back.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 40 == 0) begin
				bias      = $urandom_range(0, 2);
				push_cut  = (bias == 0) ? 75 : (bias == 1) ? 35 : 55;
				no_idle   = ($urandom_range(0, 3) == 0);
				pool_base = key_t'($urandom);
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				c = CMD_UNUSED;
			else if (r < 11)
				c = CMD_DUMP;
			else if (r < push_cut)
				c = CMD_PUSH;
			else
				c = CMD_REMOVE;
			k = key_t'($urandom);
			// narrow pool on pushes gives duplicates; removes mostly aim at
			// keys that went in lately
			if (c == CMD_PUSH && $urandom_range(0, 1))
				k = pool_base + key_t'($urandom_range(0, 7));
			else if (c == CMD_REMOVE && pushed_keys.size() != 0 && $urandom_range(0, 9) < 7)
				k = pushed_keys[$urandom_range(0, pushed_keys.size() - 1)];
			offer(c, k, 1'b0, ST_OK);
		end
		req_ch.valid <= 1'b0;

		// let the scoreboard book the final command before the drain check
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (due_results.size() != 0)
			report_mismatch("beats never delivered", due_results.size(), 0);
		$display("Ran %0d commands: %0d dumps, %0d pushes refused as full, %0d removes missed.",
			n_items, n_dumps, n_full, n_missed);
		$display("Checked %0d result beats, list reached depth %0d, %0d mismatches.",
			n_beats, peak_depth, n_errors);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: worst correct case is about 485 commands of 32 beats, each
	// beat behind the longest ready stall, near 8 ms; allow several times that.
	initial begin : watchdog
		#40ms;
		$display("Timeout: the run did not complete.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
